// File: src/neighbor_table_replace_worst_unit_macros.svh
// ----------------------------------------------------------------------------
// Neighbor table assertion macros
// Concurrent assertion wrappers used by the neighbor table RTL.
// ----------------------------------------------------------------------------
`ifndef NEIGHBOR_TABLE_REPLACE_WORST_UNIT_MACROS_SVH
`define NEIGHBOR_TABLE_REPLACE_WORST_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Property checked at every clock edge outside reset.
`define NBT_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("neighbor table assertion failed");
// Property checked at every clock edge, reset included.
`define NBT_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("neighbor table assertion failed");
`else
`define NBT_ASSERT(label, clk, rst, prop)
`define NBT_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// File: src/nbt_pkg.sv
// ----------------------------------------------------------------------------
// Neighbor table package
// Sizes, operation codes, register indexes and shared types.
// ----------------------------------------------------------------------------
package nbt_pkg;

   localparam int TABLE_SIZE = 8;
   localparam int ADDR_WIDTH = 16;
   localparam int METRIC_W   = 16;
   localparam int AGE_W      = 8;
   localparam int IDX_W      = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
   localparam int CNT_W      = $clog2(TABLE_SIZE + 1);
   localparam int OP_W       = 3;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic [AGE_W-1:0]    MAX_AGE_RESET      = AGE_W'(180);
   localparam logic [METRIC_W-1:0] METRIC_LIMIT_RESET = METRIC_W'(511);

   localparam logic [CSR_IDX_W-1:0] CSR_MAX_AGE      = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_METRIC_LIMIT = 1'b1;

   localparam logic [OP_W-1:0] OP_ADD      = 3'd0;
   localparam logic [OP_W-1:0] OP_UPDATE   = 3'd1;
   localparam logic [OP_W-1:0] OP_ACTIVITY = 3'd2;
   localparam logic [OP_W-1:0] OP_TICK     = 3'd3;
   localparam logic [OP_W-1:0] OP_REMOVE   = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_APPLY,
      ST_BEST
   } state_type;

   typedef struct packed {
      logic                  valid;
      logic [ADDR_WIDTH-1:0] addr;
      logic [METRIC_W-1:0]   metric;
      logic [AGE_W-1:0]      age;
   } entry_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] idx;
      entry_type        entry;
   } wr_type;

endpackage

// File: src/neighbor_table_replace_worst_unit.sv
// ----------------------------------------------------------------------------
// Neighbor table with worst-metric replacement and aging
// Keeps a small neighbor table; one operation per command word, one
// response word per command reporting the best neighbor.
// ----------------------------------------------------------------------------
//
//   channel   handshake            payload
//   --------  -------------------  ------------------------------------------
//   command   start, busy          req_operation, req_neighbor_addr, req_metric
//   response  rsp_valid (strobe)   rsp_accepted, rsp_best_valid, rsp_best_addr,
//                                  rsp_best_metric, rsp_entry_count
//   config    csr_valid, csr_ready csr_index, csr_wdata
//
// A command word runs from the accepting edge to its response strobe in three
// steps: one sweep over the table for match, free slot, worst entry and aging,
// an apply state that carries out the operation, and a second sweep for the
// best neighbor and the entry count. Both sweeps share the single read port of
// the table. busy drops in the strobe cycle, so the next command word may be
// taken there. Reset empties the table at once and restores max_age 180 and
// metric_limit 511. The response cannot be stalled; the config port is always ready.
//
`include "neighbor_table_replace_worst_unit_macros.svh"

module neighbor_table_replace_worst_unit
   import nbt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // command
   input  logic                  start,
   output logic                  busy,
   input  logic [OP_W-1:0]       req_operation,
   input  logic [ADDR_WIDTH-1:0] req_neighbor_addr,
   input  logic [METRIC_W-1:0]   req_metric,
   // response
   output logic                  rsp_valid,
   output logic                  rsp_accepted,
   output logic                  rsp_best_valid,
   output logic [ADDR_WIDTH-1:0] rsp_best_addr,
   output logic [METRIC_W-1:0]   rsp_best_metric,
   output logic [CNT_W-1:0]      rsp_entry_count,
   // configuration
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);
   localparam logic [AGE_W-1:0] AGE_SAT  = '1;

   // sequencer
   state_type state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;

   // latched command word
   logic [OP_W-1:0]       op_ff, op_in;
   logic [ADDR_WIDTH-1:0] addr_ff, addr_in;
   logic [METRIC_W-1:0]   metric_ff, metric_in;

   // first sweep results
   logic                match_hit_ff, match_hit_in;
   logic [IDX_W-1:0]    match_idx_ff, match_idx_in;
   logic                free_hit_ff, free_hit_in;
   logic [IDX_W-1:0]    free_idx_ff, free_idx_in;
   logic                worst_hit_ff, worst_hit_in;
   logic [IDX_W-1:0]    worst_idx_ff, worst_idx_in;
   logic [METRIC_W-1:0] worst_metric_ff, worst_metric_in;

   // shared between sweeps: valid count; second sweep: best neighbor
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  acc_ff, acc_in;
   logic                  best_hit_ff, best_hit_in;
   logic [ADDR_WIDTH-1:0] best_addr_ff, best_addr_in;
   logic [METRIC_W-1:0]   best_metric_ff, best_metric_in;

   // response word
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_acc_ff, rsp_acc_in;
   logic                  rsp_best_valid_ff, rsp_best_valid_in;
   logic [ADDR_WIDTH-1:0] rsp_best_addr_ff, rsp_best_addr_in;
   logic [METRIC_W-1:0]   rsp_best_metric_ff, rsp_best_metric_in;
   logic [CNT_W-1:0]      rsp_count_ff, rsp_count_in;

   // registers
   logic [AGE_W-1:0]    max_age_ff, max_age_in;
   logic [METRIC_W-1:0] metric_limit_ff, metric_limit_in;

   // table port
   logic [IDX_W-1:0] rd_idx;
   entry_type        rd_entry;
   wr_type           wr;
   logic [AGE_W-1:0] age_inc;
   entry_type        fresh;

   nbt_table u_table (
      .clock    (clock),
      .reset    (reset),
      .rd_idx   (rd_idx),
      .rd_entry (rd_entry),
      .wr       (wr)
   );

   // ---------------------------------------------------------------------
   // Configuration: always ready; write only while no command is in flight
   // ---------------------------------------------------------------------
   assign csr_ready = 1'b1;

   always_comb begin
      max_age_in      = max_age_ff;
      metric_limit_in = metric_limit_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MAX_AGE:      max_age_in      = csr_wdata[AGE_W-1:0];
            CSR_METRIC_LIMIT: metric_limit_in = csr_wdata[METRIC_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Sequencer: idle -> sweep one -> apply -> sweep two -> idle
   // ---------------------------------------------------------------------
   assign age_inc = (rd_entry.age == AGE_SAT) ? rd_entry.age : rd_entry.age + AGE_W'(1);

   always_comb begin
      fresh.valid  = 1'b1;
      fresh.addr   = addr_ff;
      fresh.metric = metric_ff;
      fresh.age    = '0;
   end

   always_comb begin
      state_in           = state_ff;
      idx_in             = idx_ff;
      op_in              = op_ff;
      addr_in            = addr_ff;
      metric_in          = metric_ff;
      match_hit_in       = match_hit_ff;
      match_idx_in       = match_idx_ff;
      free_hit_in        = free_hit_ff;
      free_idx_in        = free_idx_ff;
      worst_hit_in       = worst_hit_ff;
      worst_idx_in       = worst_idx_ff;
      worst_metric_in    = worst_metric_ff;
      cnt_in             = cnt_ff;
      acc_in             = acc_ff;
      best_hit_in        = best_hit_ff;
      best_addr_in       = best_addr_ff;
      best_metric_in     = best_metric_ff;
      rsp_valid_in       = 1'b0;
      rsp_acc_in         = rsp_acc_ff;
      rsp_best_valid_in  = rsp_best_valid_ff;
      rsp_best_addr_in   = rsp_best_addr_ff;
      rsp_best_metric_in = rsp_best_metric_ff;
      rsp_count_in       = rsp_count_ff;
      rd_idx             = idx_ff;
      wr                 = '0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in           = req_operation;
               addr_in         = req_neighbor_addr;
               metric_in       = req_metric;
               idx_in          = '0;
               match_hit_in    = 1'b0;
               free_hit_in     = 1'b0;
               worst_hit_in    = 1'b0;
               worst_metric_in = '0;
               cnt_in          = '0;
               state_in        = ST_SCAN;
            end
         end

         ST_SCAN: begin
            if (rd_entry.valid) begin
               cnt_in = cnt_ff + CNT_W'(1);
               if (rd_entry.addr == addr_ff && !match_hit_ff) begin
                  match_hit_in = 1'b1;
                  match_idx_in = idx_ff;
               end
               // first slot holding the strictly largest metric above zero
               if (rd_entry.metric > worst_metric_ff) begin
                  worst_hit_in    = 1'b1;
                  worst_idx_in    = idx_ff;
                  worst_metric_in = rd_entry.metric;
               end
               // age in place; drop entries that reach the limit
               if (op_ff == OP_TICK) begin
                  wr.en           = 1'b1;
                  wr.idx          = idx_ff;
                  wr.entry        = rd_entry;
                  wr.entry.age    = age_inc;
                  wr.entry.valid  = (age_inc < max_age_ff);
               end
            end else if (!free_hit_ff) begin
               free_hit_in = 1'b1;
               free_idx_in = idx_ff;
            end
            if (idx_ff == LAST_IDX) begin
               state_in = ST_APPLY;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end

         ST_APPLY: begin
            rd_idx = match_idx_ff;
            acc_in = 1'b0;
            case (op_ff)
               OP_ADD: begin
                  if (!match_hit_ff) begin
                     if (free_hit_ff) begin
                        wr.en    = 1'b1;
                        wr.idx   = free_idx_ff;
                        wr.entry = fresh;
                        acc_in   = 1'b1;
                     end else if (worst_hit_ff && worst_metric_ff > metric_ff) begin
                        // the evicted slot is the only free one left
                        wr.en    = 1'b1;
                        wr.idx   = worst_idx_ff;
                        wr.entry = fresh;
                        acc_in   = 1'b1;
                     end
                  end
               end
               OP_UPDATE: begin
                  if (match_hit_ff) begin
                     wr.en           = 1'b1;
                     wr.idx          = match_idx_ff;
                     wr.entry        = rd_entry;
                     wr.entry.metric = metric_ff;
                     wr.entry.age    = '0;
                     acc_in          = 1'b1;
                  end
               end
               OP_ACTIVITY: begin
                  if (match_hit_ff) begin
                     wr.en        = 1'b1;
                     wr.idx       = match_idx_ff;
                     wr.entry     = rd_entry;
                     wr.entry.age = '0;
                     acc_in       = 1'b1;
                  end
               end
               OP_TICK: begin
                  acc_in = 1'b1;
               end
               OP_REMOVE: begin
                  if (match_hit_ff) begin
                     wr.en          = 1'b1;
                     wr.idx         = match_idx_ff;
                     wr.entry       = rd_entry;
                     wr.entry.valid = 1'b0;
                     acc_in         = 1'b1;
                  end
               end
               default: ;
            endcase
            idx_in         = '0;
            cnt_in         = '0;
            best_hit_in    = 1'b0;
            best_addr_in   = '0;
            best_metric_in = metric_limit_ff;
            state_in       = ST_BEST;
         end

         ST_BEST: begin
            if (rd_entry.valid) begin
               cnt_in = cnt_ff + CNT_W'(1);
               // strict compare keeps the lowest slot on a tie
               if (rd_entry.metric < best_metric_ff) begin
                  best_hit_in    = 1'b1;
                  best_addr_in   = rd_entry.addr;
                  best_metric_in = rd_entry.metric;
               end
            end
            if (idx_ff == LAST_IDX) begin
               rsp_valid_in       = 1'b1;
               rsp_acc_in         = acc_ff;
               rsp_best_valid_in  = best_hit_in;
               rsp_best_addr_in   = best_addr_in;
               rsp_best_metric_in = best_metric_in;
               rsp_count_in       = cnt_in;
               state_in           = ST_IDLE;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         rsp_valid_ff    <= 1'b0;
         max_age_ff      <= MAX_AGE_RESET;
         metric_limit_ff <= METRIC_LIMIT_RESET;
      end else begin
         state_ff        <= state_in;
         rsp_valid_ff    <= rsp_valid_in;
         max_age_ff      <= max_age_in;
         metric_limit_ff <= metric_limit_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      idx_ff             <= idx_in;
      op_ff              <= op_in;
      addr_ff            <= addr_in;
      metric_ff          <= metric_in;
      match_hit_ff       <= match_hit_in;
      match_idx_ff       <= match_idx_in;
      free_hit_ff        <= free_hit_in;
      free_idx_ff        <= free_idx_in;
      worst_hit_ff       <= worst_hit_in;
      worst_idx_ff       <= worst_idx_in;
      worst_metric_ff    <= worst_metric_in;
      cnt_ff             <= cnt_in;
      acc_ff             <= acc_in;
      best_hit_ff        <= best_hit_in;
      best_addr_ff       <= best_addr_in;
      best_metric_ff     <= best_metric_in;
      rsp_acc_ff         <= rsp_acc_in;
      rsp_best_valid_ff  <= rsp_best_valid_in;
      rsp_best_addr_ff   <= rsp_best_addr_in;
      rsp_best_metric_ff <= rsp_best_metric_in;
      rsp_count_ff       <= rsp_count_in;
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_accepted    = rsp_acc_ff;
   assign rsp_best_valid  = rsp_best_valid_ff;
   assign rsp_best_addr   = rsp_best_addr_ff;
   assign rsp_best_metric = rsp_best_metric_ff;
   assign rsp_entry_count = rsp_count_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   `NBT_ASSERT(a_rsp_when_idle, clock, reset, rsp_valid |-> !busy)
   `NBT_ASSERT(a_start_goes_busy, clock, reset, (start && !busy) |=> busy)
   `NBT_ASSERT(a_rsp_single_pulse, clock, reset, rsp_valid |=> !rsp_valid)
   `NBT_ASSERT(a_count_in_range, clock, reset,
      rsp_valid |-> (rsp_entry_count <= CNT_W'(TABLE_SIZE)))
   `NBT_ASSERT(a_no_best_addr_zero, clock, reset,
      (rsp_valid && !rsp_best_valid) |-> (rsp_best_addr == '0))
   `NBT_ASSERT_ALWAYS(a_reset_clears_rsp, clock, reset |=> !rsp_valid)

endmodule

// File: src/nbt_table.sv
// ----------------------------------------------------------------------------
// Neighbor table storage
// Eight entries with one indexed read port and one write port.
// ----------------------------------------------------------------------------
module nbt_table
   import nbt_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic [IDX_W-1:0] rd_idx,
   output entry_type        rd_entry,
   input  wr_type           wr
);

   logic [TABLE_SIZE-1:0] valid_ff;
   logic [TABLE_SIZE-1:0] valid_in;
   logic [ADDR_WIDTH-1:0] addr_ff   [TABLE_SIZE];
   logic [METRIC_W-1:0]   metric_ff [TABLE_SIZE];
   logic [AGE_W-1:0]      age_ff    [TABLE_SIZE];

   always_comb begin
      valid_in = valid_ff;
      if (wr.en) begin
         valid_in[wr.idx] = wr.entry.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload holds no reset; only valid entries are ever used
   always_ff @(posedge clock) begin
      if (wr.en) begin
         addr_ff[wr.idx]   <= wr.entry.addr;
         metric_ff[wr.idx] <= wr.entry.metric;
         age_ff[wr.idx]    <= wr.entry.age;
      end
   end

   always_comb begin
      rd_entry.valid  = valid_ff[rd_idx];
      rd_entry.addr   = addr_ff[rd_idx];
      rd_entry.metric = metric_ff[rd_idx];
      rd_entry.age    = age_ff[rd_idx];
   end

endmodule

// File: test/tb_neighbor_table_replace_worst_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Neighbor table testbench
// Drives add, update, activity, tick, remove and unused command words into
// the neighbor table under several max_age / metric_limit settings and
// checks every response word against a behavioral table kept alongside.
// ----------------------------------------------------------------------------

import nbt_pkg::*;

typedef struct packed {
   logic                  accepted;
   logic                  best_valid;
   logic [ADDR_WIDTH-1:0] best_addr;
   logic [METRIC_W-1:0]   best_metric;
   logic [CNT_W-1:0]      entry_count;
} neighbor_report_type;

class neighbor_scoreboard;
   logic [AGE_W-1:0]      max_age;
   logic [METRIC_W-1:0]   metric_limit;
   bit                    live      [TABLE_SIZE];
   logic [ADDR_WIDTH-1:0] addr_of   [TABLE_SIZE];
   logic [METRIC_W-1:0]   metric_of [TABLE_SIZE];
   logic [AGE_W-1:0]      age_of    [TABLE_SIZE];
   neighbor_report_type   expected_reports [$];
   int                    mismatches;

   function new();
      max_age      = MAX_AGE_RESET;
      metric_limit = METRIC_LIMIT_RESET;
      for (int i = 0; i < TABLE_SIZE; i++) begin
         live[i]      = 1'b0;
         addr_of[i]   = '0;
         metric_of[i] = '0;
         age_of[i]    = '0;
      end
      mismatches = 0;
   endfunction

   function void write_register(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
      case (index)
         CSR_MAX_AGE:      max_age      = data[AGE_W-1:0];
         CSR_METRIC_LIMIT: metric_limit = data[METRIC_W-1:0];
         default: ;
      endcase
   endfunction

   function int slot_of(logic [ADDR_WIDTH-1:0] addr);
      for (int i = 0; i < TABLE_SIZE; i++)
         if (live[i] && addr_of[i] == addr) return i;
      return -1;
   endfunction

   function int occupancy();
      int n;
      n = 0;
      for (int i = 0; i < TABLE_SIZE; i++)
         if (live[i]) n++;
      return n;
   endfunction

   // Insert at the lowest free slot; on a full table evict the first entry
   // with the strictly largest nonzero metric, only if it beats the new one.
   function bit insert(logic [ADDR_WIDTH-1:0] addr, logic [METRIC_W-1:0] metric);
      int                  worst;
      int                  free_slot;
      logic [METRIC_W-1:0] worst_metric;
      if (slot_of(addr) >= 0) return 1'b0;
      if (occupancy() >= TABLE_SIZE) begin
         worst        = -1;
         worst_metric = '0;
         for (int i = 0; i < TABLE_SIZE; i++) begin
            if (live[i] && metric_of[i] > worst_metric) begin
               worst        = i;
               worst_metric = metric_of[i];
            end
         end
         if (worst < 0 || worst_metric <= metric) return 1'b0;
         live[worst] = 1'b0;
      end
      free_slot = -1;
      for (int i = 0; i < TABLE_SIZE; i++)
         if (!live[i] && free_slot < 0) free_slot = i;
      if (free_slot < 0) return 1'b0;
      live[free_slot]      = 1'b1;
      addr_of[free_slot]   = addr;
      metric_of[free_slot] = metric;
      age_of[free_slot]    = '0;
      return 1'b1;
   endfunction

   function void age_all();
      for (int i = 0; i < TABLE_SIZE; i++) begin
         if (live[i]) begin
            if (age_of[i] != '1) age_of[i] = age_of[i] + 1'b1;
            if (age_of[i] >= max_age) live[i] = 1'b0;
         end
      end
   endfunction

   function void note_command(logic [OP_W-1:0] op, logic [ADDR_WIDTH-1:0] addr,
                              logic [METRIC_W-1:0] metric);
      bit                  hit;
      int                  slot;
      int                  best;
      logic [METRIC_W-1:0] best_metric;
      neighbor_report_type rep;
      hit  = 1'b0;
      slot = slot_of(addr);
      case (op)
         OP_ADD: hit = insert(addr, metric);
         OP_UPDATE: begin
            if (slot >= 0) begin
               metric_of[slot] = metric;
               age_of[slot]    = '0;
               hit             = 1'b1;
            end
         end
         OP_ACTIVITY: begin
            if (slot >= 0) begin
               age_of[slot] = '0;
               hit          = 1'b1;
            end
         end
         OP_TICK: begin
            age_all();
            hit = 1'b1;
         end
         OP_REMOVE: begin
            if (slot >= 0) begin
               live[slot] = 1'b0;
               hit        = 1'b1;
            end
         end
         default: ;
      endcase
      best        = -1;
      best_metric = metric_limit;
      for (int i = 0; i < TABLE_SIZE; i++) begin
         if (live[i] && metric_of[i] < best_metric) begin
            best        = i;
            best_metric = metric_of[i];
         end
      end
      rep.accepted    = hit;
      rep.best_valid  = (best >= 0);
      rep.best_addr   = (best >= 0) ? addr_of[best] : '0;
      rep.best_metric = best_metric;
      rep.entry_count = CNT_W'(occupancy());
      expected_reports.push_back(rep);
   endfunction

   function void check_report(neighbor_report_type got);
      neighbor_report_type exp;
      if (expected_reports.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("%t: unowed response: acc %0d valid %0d addr %h metric %h count %0d",
                     $realtime, got.accepted, got.best_valid, got.best_addr, got.best_metric,
                     got.entry_count);
         return;
      end
      exp = expected_reports.pop_front();
      if (got.accepted !== exp.accepted || got.best_valid !== exp.best_valid ||
          got.best_addr !== exp.best_addr || got.best_metric !== exp.best_metric ||
          got.entry_count !== exp.entry_count) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("%t: mismatch expected acc %0d valid %0d addr %h metric %h count %0d",
                     $realtime, exp.accepted, exp.best_valid, exp.best_addr, exp.best_metric,
                     exp.entry_count);
            $display("%t: mismatch got      acc %0d valid %0d addr %h metric %h count %0d",
                     $realtime, got.accepted, got.best_valid, got.best_addr, got.best_metric,
                     got.entry_count);
         end
      end
   endfunction

   function int outstanding();
      return expected_reports.size();
   endfunction
endclass

module tb_neighbor_table_replace_worst_unit;

   // Unused operation codes: the block must ignore these.
   localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
   localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;

   localparam int NUM_PHASES      = 8;
   localparam int WORDS_PER_PHASE = 115;
   localparam int POOL_SIZE       = 12;
   // Idle time after the last word has answered, before the verdict.
   localparam int DRAIN_CYCLES    = 40;

   logic                  clock             = 1'b0;
   logic                  reset             = 1'b1;
   logic                  start             = 1'b0;
   logic                  busy;
   logic [OP_W-1:0]       req_operation     = '0;
   logic [ADDR_WIDTH-1:0] req_neighbor_addr = '0;
   logic [METRIC_W-1:0]   req_metric        = '0;
   logic                  rsp_valid;
   logic                  rsp_accepted;
   logic                  rsp_best_valid;
   logic [ADDR_WIDTH-1:0] rsp_best_addr;
   logic [METRIC_W-1:0]   rsp_best_metric;
   logic [CNT_W-1:0]      rsp_entry_count;
   logic                  csr_valid         = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index         = '0;
   logic [CSR_DATA_W-1:0] csr_wdata         = '0;

   neighbor_scoreboard    sb;
   bit                    gaps_off = 1'b0;
   logic [ADDR_WIDTH-1:0] addr_pool [POOL_SIZE];

   // Register settings per random phase; the last phase draws its own.
   int age_plan   [NUM_PHASES] = '{3, 1, 255, 8, 0, 2, 5, 120};
   int limit_plan [NUM_PHASES] = '{511, 0, 65535, 1000, 200, 40, 65535, 300};

   neighbor_table_replace_worst_unit u_top (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_operation     (req_operation),
      .req_neighbor_addr (req_neighbor_addr),
      .req_metric        (req_metric),
      .rsp_valid         (rsp_valid),
      .rsp_accepted      (rsp_accepted),
      .rsp_best_valid    (rsp_best_valid),
      .rsp_best_addr     (rsp_best_addr),
      .rsp_best_metric   (rsp_best_metric),
      .rsp_entry_count   (rsp_entry_count),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always #5 clock = ~clock;

   // Sample the response strobe at the rising edge; the receiver never stalls.
   always @(posedge clock) begin : watch_response
      neighbor_report_type got;
      if (!reset && rsp_valid) begin
         got.accepted    = rsp_accepted;
         got.best_valid  = rsp_best_valid;
         got.best_addr   = rsp_best_addr;
         got.best_metric = rsp_best_metric;
         got.entry_count = rsp_entry_count;
         sb.check_report(got);
      end
   end

   // Present one command word at the falling edge and hold it until the
   // block takes it (start high, busy low at a rising edge). Now and then
   // drop start for a random stretch so the next word lands at a different
   // point of the block's sweep; scribble the payload meanwhile.
   task automatic send_word(input logic [OP_W-1:0] op, input logic [ADDR_WIDTH-1:0] addr,
                            input logic [METRIC_W-1:0] metric);
      int gap;
      @(negedge clock);
      if (!gaps_off && $urandom_range(99) < 7) begin
         gap   = $urandom_range(1, 20);
         start = 1'b0;
         repeat (gap) begin
            req_operation     = OP_W'($urandom);
            req_neighbor_addr = ADDR_WIDTH'($urandom);
            req_metric        = METRIC_W'($urandom);
            @(negedge clock);
         end
      end
      start             = 1'b1;
      req_operation     = op;
      req_neighbor_addr = addr;
      req_metric        = metric;
      @(posedge clock);
      while (busy) @(posedge clock);
      sb.note_command(op, addr, metric);
   endtask

   // Write one register; drop start first so no word slips in alongside.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      start     = 1'b0;
      csr_valid = 1'b1;
      csr_index = index;
      csr_wdata = data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.write_register(index, data);
      @(negedge clock);
      csr_valid = 1'b0;
      csr_wdata = CSR_DATA_W'($urandom);
   endtask

   // Drop start so the last word is not taken again, then wait until every
   // word has answered; the block is idle when nothing is owed.
   task automatic wait_drained();
      @(negedge clock);
      start = 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
   endtask

   // Draw a word biased toward addresses already in play, so updates,
   // removes and duplicate adds find their targets and the table fills up.
   task automatic random_word();
      int                    pick;
      int                    lim;
      logic [OP_W-1:0]       op;
      logic [ADDR_WIDTH-1:0] addr;
      logic [METRIC_W-1:0]   metric;
      pick = $urandom_range(99);
      if (pick < 40)      op = OP_ADD;
      else if (pick < 55) op = OP_UPDATE;
      else if (pick < 67) op = OP_ACTIVITY;
      else if (pick < 81) op = OP_TICK;
      else if (pick < 97) op = OP_REMOVE;
      else                op = OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
      if ($urandom_range(99) < 85) addr = addr_pool[$urandom_range(POOL_SIZE - 1)];
      else                         addr = ADDR_WIDTH'($urandom);
      case ($urandom_range(3))
         0: metric = METRIC_W'($urandom_range(15));
         1: begin
            // straddle the limit to hit the strict comparison
            lim = int'(sb.metric_limit) + $urandom_range(4) - 2;
            if (lim < 0) lim = 0;
            if (lim > 65535) lim = 65535;
            metric = METRIC_W'(lim);
         end
         2: metric = METRIC_W'($urandom);
         default: metric = METRIC_W'($urandom_range(1023));
      endcase
      send_word(op, addr, metric);
   endtask

   task automatic directed_words();
      // single neighbor, duplicate add, misses on an unknown address
      send_word(OP_ADD, 16'h0001, 16'd100);
      send_word(OP_ADD, 16'h0001, 16'd50);
      send_word(OP_UPDATE, 16'h1234, 16'd7);
      send_word(OP_ACTIVITY, 16'h1234, 16'd0);
      send_word(OP_REMOVE, 16'h1234, 16'd0);
      // address and metric extremes; the tie at metric zero goes to slot 0
      send_word(OP_ADD, 16'h0000, 16'h0000);
      send_word(OP_ADD, 16'hFFFF, 16'hFFFF);
      send_word(OP_UPDATE, 16'h0001, 16'h0000);
      send_word(OP_ACTIVITY, 16'hFFFF, 16'd3);
      send_word(OP_TICK, ADDR_WIDTH'($urandom), METRIC_W'($urandom));
      send_word(OP_REMOVE, 16'h0001, 16'd0);
      for (int code = OP_SPARE_FIRST; code <= OP_SPARE_LAST; code++)
         send_word(OP_W'(code), ADDR_WIDTH'($urandom), METRIC_W'($urandom));
      // fill up, then: worse add refused, better add evicts the worst,
      // add equal to the worst refused
      for (int i = 0; i < 6; i++)
         send_word(OP_ADD, ADDR_WIDTH'(16'h0010 + i), METRIC_W'(200 + 100 * i));
      send_word(OP_ADD, 16'h0020, 16'hFFFF);
      send_word(OP_ADD, 16'h0021, 16'd1);
      send_word(OP_ADD, 16'h0022, 16'd700);
      // max_age zero clears the whole table on the next tick
      wait_drained();
      write_reg(CSR_MAX_AGE, '0);
      send_word(OP_TICK, ADDR_WIDTH'($urandom), METRIC_W'($urandom));
      // full table of zero metrics has no worst entry: no eviction
      for (int i = 0; i < TABLE_SIZE; i++)
         send_word(OP_ADD, ADDR_WIDTH'(16'h0030 + i), 16'h0000);
      send_word(OP_ADD, 16'h0040, 16'h0000);
   endtask

   initial begin
      sb = new();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Run the directed words, starting from the reset register values.
      directed_words();

      for (int p = 0; p < NUM_PHASES; p++) begin
         wait_drained();
         if (p == NUM_PHASES - 1) begin
            age_plan[p]   = $urandom_range(255);
            limit_plan[p] = $urandom_range(65535);
         end
         write_reg(CSR_MAX_AGE, CSR_DATA_W'(age_plan[p]));
         write_reg(CSR_METRIC_LIMIT, CSR_DATA_W'(limit_plan[p]));
         // keep one phase back to back with no gaps at all
         gaps_off = (p == 2);
         addr_pool[0] = 16'h0000;
         addr_pool[1] = 16'hFFFF;
         for (int i = 2; i < POOL_SIZE; i++) addr_pool[i] = ADDR_WIDTH'($urandom);
         repeat (WORDS_PER_PHASE) random_word();
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // Hard stop far beyond the slowest legal run.
   initial begin
      #5_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
